// File: hdl/assert_macros.svh
// Assertion macros shared by the matcher's RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check a condition at every clock edge outside reset.
`define AST_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
// Check that a condition in one cycle implies another in the next cycle.
`define AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: hdl/wmpm_pkg.sv
// Package of the matcher: sizes, codes, control structs and the saturating add.
package wmpm_pkg;

  localparam int MAX_NODES  = 1024;
  localparam int ALPHABET   = 26;
  localparam int SCORE_BITS = 48;
  localparam int NODE_W     = $clog2(MAX_NODES);
  localparam int CNT_W      = NODE_W + 1;
  localparam int LET_W      = 5;
  localparam int WEIGHT_W   = 20;
  localparam int CMD_W      = 2;
  localparam int STAT_W     = 2;

  typedef logic [ALPHABET-1:0][NODE_W-1:0] row_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_PAT   = 2'd0,
    CMD_BUILD = 2'd1,
    CMD_TEXT  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EARLY = 2'd2,
    ST_LATE  = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_INIT,
    OP_CLR,
    OP_C_DONE,
    OP_REJ,
    OP_P_RD,
    OP_P_DEC,
    OP_P_SCW,
    OP_B_START,
    OP_B_ROOT,
    OP_B_POP,
    OP_B_FAIL,
    OP_B_RDU,
    OP_B_RDL,
    OP_B_SCW,
    OP_B_LOOP,
    OP_B_WRU,
    OP_B_DONE,
    OP_T_RD,
    OP_T_PICK,
    OP_T_SUM
  } dp_op_t;

  // Controller to datapath.
  typedef struct packed {
    dp_op_t op;
    logic   accept;
    logic   load_out;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    cmd_t cmd;
    logic built;
    logic letter_ok;
    logic pend;
    logic p_full;
    logic idx_last;
    logic q_empty;
    logic clr_last;
  } dp_stat_t;

  localparam logic [SCORE_BITS-1:0] SCORE_MAX = '1;

  function automatic logic [SCORE_BITS-1:0] sat_add(input logic [SCORE_BITS-1:0] a,
                                                    input logic [SCORE_BITS-1:0] b);
    logic [SCORE_BITS:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[SCORE_BITS] ? SCORE_MAX : sum[SCORE_BITS-1:0];
  endfunction

endpackage

// File: hdl/wmpm_if.sv
// Channel interfaces: input word and result word, each with valid/ready.
interface wmpm_in_if;
  logic                        valid;
  logic                        ready;
  logic [wmpm_pkg::CMD_W-1:0]  command;
  logic [wmpm_pkg::LET_W-1:0]  letter;
  logic                        pattern_end;
  logic [wmpm_pkg::WEIGHT_W-1:0] weight;
  logic                        text_start;
  modport source (output valid, command, letter, pattern_end, weight, text_start,
                  input ready);
  modport sink (input valid, command, letter, pattern_end, weight, text_start,
                output ready);
endinterface

interface wmpm_out_if;
  logic                            valid;
  logic                            ready;
  logic [wmpm_pkg::STAT_W-1:0]     status;
  logic [wmpm_pkg::SCORE_BITS-1:0] position_score;
  logic [wmpm_pkg::SCORE_BITS-1:0] running_total;
  logic [wmpm_pkg::NODE_W-1:0]     current_node;
  modport source (output valid, status, position_score, running_total, current_node,
                  input ready);
  modport sink (input valid, status, position_score, running_total, current_node,
                output ready);
endinterface

// File: hdl/wmpm_dp.sv
// Datapath: trie row store, scores, failure links, walk queue and result registers.
`include "assert_macros.svh"
module wmpm_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  wmpm_pkg::dp_cmd_t               cmd,
  output wmpm_pkg::dp_stat_t              st,
  input  logic [wmpm_pkg::CMD_W-1:0]      in_command,
  input  logic [wmpm_pkg::LET_W-1:0]      in_letter,
  input  logic                            in_pattern_end,
  input  logic [wmpm_pkg::WEIGHT_W-1:0]   in_weight,
  input  logic                            in_text_start,
  output logic [wmpm_pkg::STAT_W-1:0]     out_status,
  output logic [wmpm_pkg::SCORE_BITS-1:0] out_position_score,
  output logic [wmpm_pkg::SCORE_BITS-1:0] out_running_total,
  output logic [wmpm_pkg::NODE_W-1:0]     out_current_node
);

  localparam int NW = wmpm_pkg::NODE_W;
  localparam int SW = wmpm_pkg::SCORE_BITS;
  localparam int CW = wmpm_pkg::CNT_W;
  localparam int LW = wmpm_pkg::LET_W;

  // Memories
  wmpm_pkg::row_t goto_mem [wmpm_pkg::MAX_NODES];
  logic [SW-1:0]  score_mem [wmpm_pkg::MAX_NODES];
  logic [NW-1:0]  fail_mem [wmpm_pkg::MAX_NODES];
  logic [NW-1:0]  queue_mem [wmpm_pkg::MAX_NODES];

  wmpm_pkg::row_t row_q_r;
  logic [SW-1:0]  score_q_r;
  logic [NW-1:0]  fail_q_r, queue_q_r;

  // Latched input word
  wmpm_pkg::cmd_t    cmd_r;
  logic [LW-1:0]     letter_r;
  logic              pend_r, tstart_r;
  logic [wmpm_pkg::WEIGHT_W-1:0] weight_r;

  // Control state
  logic [CW-1:0] node_count_r, node_count_nxt;
  logic [NW-1:0] cursor_r, cursor_nxt;
  logic [NW-1:0] scan_r, scan_nxt;
  logic [SW-1:0] total_r, total_nxt;
  logic          built_r, built_nxt;
  logic [NW-1:0] clr_addr_r, clr_addr_nxt;
  logic [CW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [LW-1:0] idx_r, idx_nxt;

  // Build working registers
  logic [NW-1:0]  bu_r, bu_nxt, l_r, l_nxt;
  wmpm_pkg::row_t row_u_r, row_u_nxt, row_l_r, row_l_nxt;
  logic [SW-1:0]  scu_r, scu_nxt;

  // Result
  wmpm_pkg::status_t res_status_r, res_status_nxt;
  logic [SW-1:0]     res_pos_r, res_pos_nxt, res_total_r, res_total_nxt;
  logic [NW-1:0]     res_node_r, res_node_nxt;
  logic [wmpm_pkg::STAT_W-1:0] o_status_r;
  logic [SW-1:0]     o_pos_r, o_total_r;
  logic [NW-1:0]     o_node_r;

  // Memory port controls
  logic [NW-1:0]  row_ra, row_wa, sc_ra, sc_wa, fail_ra, fail_wa, q_ra, q_wa;
  logic           row_we, sc_we, fail_we, q_we;
  wmpm_pkg::row_t row_wd;
  logic [SW-1:0]  sc_wd;
  logic [NW-1:0]  fail_wd, q_wd;

  // Derived values
  logic          letter_ok;
  logic [NW-1:0] p_nxt, p_target, lc, lt, t_nxt;
  logic          p_full;
  wmpm_pkg::row_t row_mod;

  assign letter_ok = letter_r < LW'(wmpm_pkg::ALPHABET);
  assign p_nxt     = row_q_r[letter_r];
  assign p_full    = (p_nxt == '0) && (node_count_r >= CW'(wmpm_pkg::MAX_NODES - 1));
  assign p_target  = (p_nxt == '0) ? NW'(node_count_r + 1'b1) : p_nxt;
  assign lc        = row_u_r[idx_r];
  assign lt        = row_l_r[idx_r];
  assign t_nxt     = letter_ok ? row_q_r[letter_r] : '0;

  always_comb begin
    row_mod = row_q_r;
    row_mod[letter_r] = p_target;
  end

  assign st.cmd       = cmd_r;
  assign st.built     = built_r;
  assign st.letter_ok = letter_ok;
  assign st.pend      = pend_r;
  assign st.p_full    = p_full;
  assign st.idx_last  = idx_r == LW'(wmpm_pkg::ALPHABET - 1);
  assign st.q_empty   = head_r == tail_r;
  assign st.clr_last  = clr_addr_r == NW'(wmpm_pkg::MAX_NODES - 1);

  // Operation decode
  always_comb begin
    node_count_nxt = node_count_r;
    cursor_nxt     = cursor_r;
    scan_nxt       = scan_r;
    total_nxt      = total_r;
    built_nxt      = built_r;
    clr_addr_nxt   = clr_addr_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    idx_nxt        = idx_r;
    bu_nxt         = bu_r;
    l_nxt          = l_r;
    row_u_nxt      = row_u_r;
    row_l_nxt      = row_l_r;
    scu_nxt        = scu_r;
    res_status_nxt = res_status_r;
    res_pos_nxt    = res_pos_r;
    res_total_nxt  = res_total_r;
    res_node_nxt   = res_node_r;
    row_ra = '0; row_wa = '0; row_we = 1'b0; row_wd = row_u_r;
    sc_ra = '0; sc_wa = '0; sc_we = 1'b0; sc_wd = '0;
    fail_ra = '0; fail_wa = lc; fail_we = 1'b0; fail_wd = lt;
    q_ra = head_r[NW-1:0]; q_wa = tail_r[NW-1:0]; q_we = 1'b0; q_wd = lc;
    unique case (cmd.op)
      wmpm_pkg::OP_NONE: ;
      wmpm_pkg::OP_INIT: begin
        node_count_nxt = '0; cursor_nxt = '0; scan_nxt = '0; total_nxt = '0;
        built_nxt = 1'b0; clr_addr_nxt = '0;
      end
      wmpm_pkg::OP_CLR: begin
        row_wa = clr_addr_r; row_wd = '0; row_we = 1'b1;
        sc_wa = clr_addr_r; sc_wd = '0; sc_we = 1'b1;
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
      wmpm_pkg::OP_C_DONE: begin
        res_status_nxt = wmpm_pkg::ST_OK; res_node_nxt = '0;
        res_pos_nxt = '0; res_total_nxt = '0;
      end
      wmpm_pkg::OP_REJ: begin
        res_pos_nxt = '0; res_total_nxt = '0;
        case (cmd_r)
          wmpm_pkg::CMD_PAT: begin
            res_status_nxt = built_r ? wmpm_pkg::ST_LATE : wmpm_pkg::ST_OK;
            res_node_nxt = cursor_r;
          end
          wmpm_pkg::CMD_BUILD: begin
            res_status_nxt = wmpm_pkg::ST_LATE; res_node_nxt = '0;
          end
          default: begin
            res_status_nxt = wmpm_pkg::ST_EARLY; res_node_nxt = scan_r;
          end
        endcase
      end
      wmpm_pkg::OP_P_RD: row_ra = cursor_r;
      wmpm_pkg::OP_P_DEC: begin
        res_pos_nxt = '0; res_total_nxt = '0;
        if (p_full) begin
          res_status_nxt = wmpm_pkg::ST_FULL;
          res_node_nxt = cursor_r;
          if (pend_r) cursor_nxt = '0;
        end else begin
          res_status_nxt = wmpm_pkg::ST_OK;
          res_node_nxt = p_target;
          cursor_nxt = pend_r ? '0 : p_target;
          sc_ra = p_target;
          if (p_nxt == '0) begin
            node_count_nxt = node_count_r + 1'b1;
            row_wa = cursor_r; row_wd = row_mod; row_we = 1'b1;
          end
        end
      end
      wmpm_pkg::OP_P_SCW: begin
        sc_wa = res_node_r; sc_we = 1'b1;
        sc_wd = wmpm_pkg::sat_add(score_q_r, SW'(weight_r));
      end
      wmpm_pkg::OP_B_START: begin
        head_nxt = '0; tail_nxt = '0; bu_nxt = '0; row_ra = '0;
      end
      wmpm_pkg::OP_B_ROOT: begin
        row_u_nxt = row_q_r; row_l_nxt = '0; idx_nxt = '0;
      end
      wmpm_pkg::OP_B_POP: begin
        q_ra = head_r[NW-1:0]; head_nxt = head_r + 1'b1;
      end
      wmpm_pkg::OP_B_FAIL: begin
        bu_nxt = queue_q_r; fail_ra = queue_q_r;
      end
      wmpm_pkg::OP_B_RDU: begin
        l_nxt = fail_q_r; row_ra = bu_r; sc_ra = bu_r;
      end
      wmpm_pkg::OP_B_RDL: begin
        row_u_nxt = row_q_r; scu_nxt = score_q_r; row_ra = l_r; sc_ra = l_r;
      end
      wmpm_pkg::OP_B_SCW: begin
        row_l_nxt = row_q_r; idx_nxt = '0;
        sc_wa = bu_r; sc_we = 1'b1; sc_wd = wmpm_pkg::sat_add(scu_r, score_q_r);
      end
      wmpm_pkg::OP_B_LOOP: begin
        idx_nxt = idx_r + 1'b1;
        if (lc == '0) begin
          row_u_nxt[idx_r] = lt;
        end else begin
          fail_we = 1'b1;
          if (tail_r != CW'(wmpm_pkg::MAX_NODES)) begin
            q_we = 1'b1; tail_nxt = tail_r + 1'b1;
          end
        end
      end
      wmpm_pkg::OP_B_WRU: begin
        row_wa = bu_r; row_wd = row_u_r; row_we = 1'b1;
      end
      wmpm_pkg::OP_B_DONE: begin
        built_nxt = 1'b1; cursor_nxt = '0; scan_nxt = '0; total_nxt = '0;
        res_status_nxt = wmpm_pkg::ST_OK; res_node_nxt = '0;
        res_pos_nxt = '0; res_total_nxt = '0;
      end
      wmpm_pkg::OP_T_RD: begin
        row_ra = tstart_r ? '0 : scan_r;
        if (tstart_r) begin
          scan_nxt = '0; total_nxt = '0;
        end
      end
      wmpm_pkg::OP_T_PICK: begin
        scan_nxt = t_nxt; sc_ra = t_nxt;
      end
      wmpm_pkg::OP_T_SUM: begin
        total_nxt = wmpm_pkg::sat_add(total_r, score_q_r);
        res_status_nxt = wmpm_pkg::ST_OK; res_node_nxt = scan_r;
        res_pos_nxt = score_q_r; res_total_nxt = total_nxt;
      end
      default: ;
    endcase
  end

  // Memory ports
  always_ff @(posedge clk) begin
    if (row_we) goto_mem[row_wa] <= row_wd;
    row_q_r <= goto_mem[row_ra];
    if (sc_we) score_mem[sc_wa] <= sc_wd;
    score_q_r <= score_mem[sc_ra];
    if (fail_we) fail_mem[fail_wa] <= fail_wd;
    fail_q_r <= fail_mem[fail_ra];
    if (q_we) queue_mem[q_wa] <= q_wd;
    queue_q_r <= queue_mem[q_ra];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= '0;
      cursor_r     <= '0;
      scan_r       <= '0;
      total_r      <= '0;
      built_r      <= 1'b0;
      clr_addr_r   <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      idx_r        <= '0;
    end else begin
      node_count_r <= node_count_nxt;
      cursor_r     <= cursor_nxt;
      scan_r       <= scan_nxt;
      total_r      <= total_nxt;
      built_r      <= built_nxt;
      clr_addr_r   <= clr_addr_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      idx_r        <= idx_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r    <= wmpm_pkg::cmd_t'(in_command);
      letter_r <= in_letter;
      pend_r   <= in_pattern_end;
      weight_r <= in_weight;
      tstart_r <= in_text_start;
    end
    bu_r         <= bu_nxt;
    l_r          <= l_nxt;
    row_u_r      <= row_u_nxt;
    row_l_r      <= row_l_nxt;
    scu_r        <= scu_nxt;
    res_status_r <= res_status_nxt;
    res_pos_r    <= res_pos_nxt;
    res_total_r  <= res_total_nxt;
    res_node_r   <= res_node_nxt;
    if (cmd.load_out) begin
      o_status_r <= res_status_r;
      o_pos_r    <= res_pos_r;
      o_total_r  <= res_total_r;
      o_node_r   <= res_node_r;
    end
  end

  assign out_status         = o_status_r;
  assign out_position_score = o_pos_r;
  assign out_running_total  = o_total_r;
  assign out_current_node   = o_node_r;

  `AST_ALWAYS(a_count_bound, node_count_r <= CW'(wmpm_pkg::MAX_NODES - 1))
  `AST_ALWAYS(a_queue_order, head_r <= tail_r)

endmodule

// File: hdl/wmpm_ctrl.sv
// Controller: sequences clear sweep, trie insert, breadth-first build and text steps.
`include "assert_macros.svh"
module wmpm_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  wmpm_pkg::dp_stat_t     st,
  output wmpm_pkg::dp_cmd_t      cmd
);

  typedef enum logic [4:0] {
    S_CLR, S_CDONE, S_IDLE, S_DISP,
    S_P_DEC, S_P_SCW,
    S_B_ROOT, S_B_POP, S_B_FAIL, S_B_RDU, S_B_RDL, S_B_SCW, S_B_LOOP, S_B_WRU, S_B_DONE,
    S_T_PICK, S_T_SUM, S_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic   clr_cmd_r, clr_cmd_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

  // Next state and datapath command
  always_comb begin
    state_nxt    = state_r;
    clr_cmd_nxt  = clr_cmd_r;
    cmd.op       = wmpm_pkg::OP_NONE;
    cmd.accept   = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state_r)
      S_CLR: begin
        cmd.op = wmpm_pkg::OP_CLR;
        if (st.clr_last) state_nxt = clr_cmd_r ? S_CDONE : S_IDLE;
      end
      S_CDONE: begin
        cmd.op = wmpm_pkg::OP_C_DONE;
        state_nxt = S_RESP;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        unique case (st.cmd)
          wmpm_pkg::CMD_PAT: begin
            if (st.built || !st.letter_ok) begin
              cmd.op = wmpm_pkg::OP_REJ; state_nxt = S_RESP;
            end else begin
              cmd.op = wmpm_pkg::OP_P_RD; state_nxt = S_P_DEC;
            end
          end
          wmpm_pkg::CMD_BUILD: begin
            if (st.built) begin
              cmd.op = wmpm_pkg::OP_REJ; state_nxt = S_RESP;
            end else begin
              cmd.op = wmpm_pkg::OP_B_START; state_nxt = S_B_ROOT;
            end
          end
          wmpm_pkg::CMD_TEXT: begin
            if (!st.built) begin
              cmd.op = wmpm_pkg::OP_REJ; state_nxt = S_RESP;
            end else begin
              cmd.op = wmpm_pkg::OP_T_RD; state_nxt = S_T_PICK;
            end
          end
          default: begin
            cmd.op = wmpm_pkg::OP_INIT; clr_cmd_nxt = 1'b1; state_nxt = S_CLR;
          end
        endcase
      end
      S_P_DEC: begin
        cmd.op = wmpm_pkg::OP_P_DEC;
        state_nxt = (!st.p_full && st.pend) ? S_P_SCW : S_RESP;
      end
      S_P_SCW: begin
        cmd.op = wmpm_pkg::OP_P_SCW; state_nxt = S_RESP;
      end
      S_B_ROOT: begin
        cmd.op = wmpm_pkg::OP_B_ROOT; state_nxt = S_B_LOOP;
      end
      S_B_POP: begin
        cmd.op = wmpm_pkg::OP_B_POP; state_nxt = S_B_FAIL;
      end
      S_B_FAIL: begin
        cmd.op = wmpm_pkg::OP_B_FAIL; state_nxt = S_B_RDU;
      end
      S_B_RDU: begin
        cmd.op = wmpm_pkg::OP_B_RDU; state_nxt = S_B_RDL;
      end
      S_B_RDL: begin
        cmd.op = wmpm_pkg::OP_B_RDL; state_nxt = S_B_SCW;
      end
      S_B_SCW: begin
        cmd.op = wmpm_pkg::OP_B_SCW; state_nxt = S_B_LOOP;
      end
      S_B_LOOP: begin
        cmd.op = wmpm_pkg::OP_B_LOOP;
        if (st.idx_last) state_nxt = S_B_WRU;
      end
      S_B_WRU: begin
        cmd.op = wmpm_pkg::OP_B_WRU;
        state_nxt = st.q_empty ? S_B_DONE : S_B_POP;
      end
      S_B_DONE: begin
        cmd.op = wmpm_pkg::OP_B_DONE; state_nxt = S_RESP;
      end
      S_T_PICK: begin
        cmd.op = wmpm_pkg::OP_T_PICK; state_nxt = S_T_SUM;
      end
      S_T_SUM: begin
        cmd.op = wmpm_pkg::OP_T_SUM; state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cmd_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cmd_r   <= (state_r == S_CDONE) ? 1'b0 : clr_cmd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `AST_ALWAYS(a_no_overwrite, !cmd.load_out || !out_valid_r || out_ready)
  `AST_NEXT(a_accept_busy, in_valid && in_ready, state_r == S_DISP)

endmodule

// File: hdl/weighted_multi_pattern_matcher.sv
// Weighted multi-pattern matcher: load pattern letters, build once, then score text.
// One word is in work at a time; a finished result waits in an output register while
// the next word is taken. Past accept and dispatch, a pattern letter runs a decode
// step, plus a score write when it ends a pattern and is not dropped for a full
// store; a text letter runs pick and sum; a rejected word goes right to the output
// load, as all words do last. A build walks the trie breadth-first, sweeping each
// node's 26 transitions letter by letter in the row store. After reset and after a
// clear word, row and score stores are zeroed one node a cycle, accepting no word.
module weighted_multi_pattern_matcher (
  input logic         clk,
  input logic         rst_n,
  wmpm_in_if.sink     in_ch,
  wmpm_out_if.source  out_ch
);

  wmpm_pkg::dp_cmd_t  dp_cmd;
  wmpm_pkg::dp_stat_t dp_st;

  wmpm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .st        (dp_st),
    .cmd       (dp_cmd)
  );

  wmpm_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (dp_cmd),
    .st                 (dp_st),
    .in_command         (in_ch.command),
    .in_letter          (in_ch.letter),
    .in_pattern_end     (in_ch.pattern_end),
    .in_weight          (in_ch.weight),
    .in_text_start      (in_ch.text_start),
    .out_status         (out_ch.status),
    .out_position_score (out_ch.position_score),
    .out_running_total  (out_ch.running_total),
    .out_current_node   (out_ch.current_node)
  );

endmodule
